FILE: sv/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// shared types and codes for the indexed list engine
// ----------------------------------------------------------------------------
package ile_pkg;

    // command codes
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_INS = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // value returned by everything but a successful get
    localparam logic signed [31:0] NEG_ONE = -32'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GET,
        ST_INS,
        ST_DEL
    } t_state;

endpackage

FILE: sv/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// ordered list of up to DEPTH signed 32-bit values with get, insert, delete
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low. Every
// command gives exactly one result beat: o_result_valid is high for a single
// cycle and the receiver cannot stall it, so it must take the result then.
// The list lives in one synchronous single-write memory with a registered
// read. Commands run as follows:
//   - rejected commands (out of range, list full, unknown code): busy stays
//     low, so the next command may follow at once
//   - get: memory read, then result register
//   - insert and delete: a sweep over the entries behind the position
// Insert and delete move entries one memory word per cycle through the
// read port and write each back in the next cycle, so their cost follows
// the number of entries behind the position; the result waits until the
// last write-back has landed. A head insert into a full-minus-one list and
// a head delete from a full list are the slowest cases.
// No clearing pass is needed after reset: only entries below the count are
// ever read, and those have been written.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command beat
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value,
    // result beat
    output logic               o_result_valid,
    output logic signed [31:0] o_read_value,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count
);
    import ile_pkg::*;

    // memory address, count and a compare width that holds both count and position
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    // list storage
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rdata;

    // control
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx,   n_idx;      // sweep cursor (destination entry)
    logic [CW-1:0]      r_pos,   n_pos;
    logic signed [31:0] r_value, n_value;
    logic               r_wpend, n_wpend;    // read data due for write-back
    logic [AW-1:0]      r_waddr, n_waddr;

    // result register
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_value, n_out_value;
    logic [1:0]         r_out_status, n_out_status;
    logic [4:0]         r_out_count, n_out_count;

    // memory port controls
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;

    logic [XW-1:0]      w_pos_x;
    logic [XW-1:0]      w_cnt_x;
    logic [CW-1:0]      w_idx_dn;
    logic [CW-1:0]      w_idx_up;
    logic [CW-1:0]      w_cnt_inc;
    logic [CW-1:0]      w_cnt_dec;

    // entry count as reported: low five bits
    function automatic logic [4:0] cnt_out(input logic [CW-1:0] c);
        logic [XW-1:0] x;
        x = XW'(c);
        return x[4:0];
    endfunction

    assign w_pos_x   = XW'(i_position);
    assign w_cnt_x   = XW'(r_count);
    assign w_idx_dn  = r_idx - 1'b1;
    assign w_idx_up  = r_idx + 1'b1;
    assign w_cnt_inc = r_count + 1'b1;
    assign w_cnt_dec = r_count - 1'b1;

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and cursor registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_value      <= n_value;
        r_waddr      <= n_waddr;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_value      = r_value;
        n_wpend      = 1'b0;
        n_waddr      = r_waddr;
        n_out_valid  = 1'b0;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        // the pending write-back owns the write port by default
        w_we         = r_wpend;
        w_waddr      = r_waddr;
        w_wdata      = r_rdata;
        w_raddr      = r_idx[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // rejected commands report straight away
                    n_out_value  = NEG_ONE;
                    n_out_status = STAT_RANGE;
                    n_out_count  = cnt_out(r_count);
                    case (i_command)
                        CMD_GET: begin
                            if (w_pos_x < w_cnt_x) begin
                                w_raddr = w_pos_x[AW-1:0];
                                n_state = ST_GET;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        CMD_INS: begin
                            if (w_pos_x > w_cnt_x) begin
                                n_out_valid = 1'b1;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = STAT_FULL;
                            end else begin
                                // shift from the tail down to the position
                                n_idx   = r_count;
                                n_pos   = w_pos_x[CW-1:0];
                                n_value = i_value;
                                n_state = ST_INS;
                            end
                        end
                        CMD_DEL: begin
                            if (w_pos_x < w_cnt_x) begin
                                // pull entries down from the position to the tail
                                n_idx   = w_pos_x[CW-1:0];
                                n_state = ST_DEL;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_GET: begin
                n_out_valid  = 1'b1;
                n_out_value  = r_rdata;
                n_out_status = STAT_DONE;
                n_out_count  = cnt_out(r_count);
                n_state      = ST_IDLE;
            end

            ST_INS: begin
                if (r_idx != r_pos) begin
                    w_raddr = w_idx_dn[AW-1:0];
                    n_wpend = 1'b1;
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = w_idx_dn;
                end else if (!r_wpend) begin
                    w_we         = 1'b1;
                    w_waddr      = r_idx[AW-1:0];
                    w_wdata      = r_value;
                    n_count      = w_cnt_inc;
                    n_out_valid  = 1'b1;
                    n_out_value  = NEG_ONE;
                    n_out_status = STAT_DONE;
                    n_out_count  = cnt_out(w_cnt_inc);
                    n_state      = ST_IDLE;
                end
            end

            ST_DEL: begin
                if (w_idx_up < r_count) begin
                    w_raddr = w_idx_up[AW-1:0];
                    n_wpend = 1'b1;
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = w_idx_up;
                end else if (!r_wpend) begin
                    n_count      = w_cnt_dec;
                    n_out_valid  = 1'b1;
                    n_out_value  = NEG_ONE;
                    n_out_status = STAT_DONE;
                    n_out_count  = cnt_out(w_cnt_dec);
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // count never passes the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a long command does not show a result on the cycle it goes busy
    a_no_result_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_result_valid)
        else $error("result strobe while entering a busy command");

    // a full report only when the list is really full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status on a list with room");

    // every rejected result returns minus one
    a_neg_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STAT_DONE) |-> (o_read_value == NEG_ONE))
        else $error("rejected command returned data");

    // no write-back is left over once the engine is idle
    a_wb_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_wpend)
        else $error("write-back pending in idle");

endmodule
